// ===== src/assert_macros.svh =====
// Assertion macros shared by the velocity PI controller RTL.
// Needs nothing else; files that assert include it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DAVPI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// When cond holds at one edge, prop must hold at the next edge.
`define DAVPI_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/davpi_pkg.sv =====
// Shared widths, types and arithmetic helpers for the dual-axis velocity PI controller.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package davpi_pkg;

    // Field widths.
    localparam int VEL_W     = 16;
    localparam int INTEG_W   = 32;
    localparam int GAIN_W    = 12;
    localparam int HEAD_W    = 16;
    localparam int CMD_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = (VEL_W > GAIN_W) ? VEL_W : GAIN_W;

    // Fixed-point scaling: integrator weight 1/512, command scale 1/256.
    localparam int INTEG_SHIFT = 9;
    localparam int CMD_SHIFT   = 8;
    localparam int SCALE_SHIFT = INTEG_SHIFT + CMD_SHIFT;

    // Derived datapath widths.
    localparam int ERR_W    = VEL_W + 1;
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + INTEG_W;
    localparam int NUM_W    = ((PROD_P_W + INTEG_SHIFT > PROD_I_W) ?
                               (PROD_P_W + INTEG_SHIFT) : PROD_I_W) + 1;
    localparam int Q_W      = NUM_W - SCALE_SHIFT + 1;

    // Register reset values.
    localparam logic [GAIN_W-1:0] RST_P_GAIN = GAIN_W'(400);
    localparam logic [GAIN_W-1:0] RST_I_GAIN = GAIN_W'(20);
    localparam logic [GAIN_W-1:0] RST_LIMIT  = GAIN_W'(1500);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROLL_P_GAIN  = 3'd0,
        CFG_ROLL_I_GAIN  = 3'd1,
        CFG_PITCH_P_GAIN = 3'd2,
        CFG_PITCH_I_GAIN = 3'd3,
        CFG_TARGET_VEL_X = 3'd4,
        CFG_TARGET_VEL_Y = 3'd5,
        CFG_CMD_LIMIT    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic        [GAIN_W-1:0] roll_p_gain;
        logic        [GAIN_W-1:0] roll_i_gain;
        logic        [GAIN_W-1:0] pitch_p_gain;
        logic        [GAIN_W-1:0] pitch_i_gain;
        logic signed [VEL_W-1:0]  target_vel_x;
        logic signed [VEL_W-1:0]  target_vel_y;
        logic        [GAIN_W-1:0] command_limit;
    } t_cfg;

    // What an item does to the controller state.
    typedef enum logic [1:0] {
        K_HOLD,
        K_UPDATE,
        K_ENTER
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic signed [HEAD_W-1:0] heading;
    } t_tag;

    // Divide the PI numerator by 2^SCALE_SHIFT truncating toward zero, optionally
    // negate, and clamp to +/- lim.
    function automatic logic signed [CMD_W-1:0] f_cmd(
        input logic signed [NUM_W-1:0] num,
        input logic                    neg,
        input logic        [GAIN_W-1:0] lim
    );
        logic signed [NUM_W-1:0] biased;
        logic signed [Q_W-1:0]   q;
        logic signed [Q_W-1:0]   lim_s;
        biased = num + (num[NUM_W-1] ? NUM_W'((1 << SCALE_SHIFT) - 1) : NUM_W'(0));
        q      = Q_W'(biased >>> SCALE_SHIFT);
        if (neg) begin
            q = -q;
        end
        lim_s = $signed(Q_W'(lim));
        if (q > lim_s) begin
            q = lim_s;
        end else if (q < -lim_s) begin
            q = -lim_s;
        end
        return CMD_W'(q);
    endfunction

endpackage

`default_nettype wire

// ===== src/dual_axis_velocity_pi_controller.sv =====
// Top level of the dual-axis velocity PI controller: handshake pipeline and command stage.
// Depends on davpi_pkg, davpi_cfg, davpi_integ, davpi_law and assert_macros.svh.
`default_nettype none

// Two PI velocity loops that turn measured x/y velocity (signed Q8.8) into
// pitch and roll setpoints. The y axis feeds roll; the x axis feeds pitch with
// its sign negated. A velocity beat in module mode updates both integrators
// (saturating at 32 bits) and both commands; a velocity beat outside module mode
// leaves all state alone and repeats the held commands with updated low. An
// enter beat clears the integrators, zeroes roll and pitch and stores the
// heading. Every input beat produces exactly one output beat. The block accepts
// one beat per cycle while o_stall is low, and each beat passes five
// registers on its way to the output: input register, error and integrator
// stage, multiply stage, numerator add stage, and the command register that
// drives the outputs. The only loop from one beat to the next is the integrator
// add, so beats may follow each other with no gap. The stages are independently
// valid, so holes close up under output stall and the input keeps taking beats
// until the pipeline is full. Configuration writes are always accepted
// (o_cfg_ready is tied high) and must only be issued while no beat is in flight.
// Register indexes: 0 roll P gain, 1 roll I gain, 2 pitch P gain, 3 pitch I gain,
// 4 target x velocity, 5 target y velocity, 6 command limit; index 7 is ignored.
module dual_axis_velocity_pi_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_func,
    input  logic                                i_mode_active,
    input  logic signed [davpi_pkg::VEL_W-1:0]  i_meas_vel_x,
    input  logic signed [davpi_pkg::VEL_W-1:0]  i_meas_vel_y,
    input  logic signed [davpi_pkg::HEAD_W-1:0] i_current_heading,
    // Output channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [davpi_pkg::CMD_W-1:0]  o_roll_cmd,
    output logic signed [davpi_pkg::CMD_W-1:0]  o_pitch_cmd,
    output logic signed [davpi_pkg::HEAD_W-1:0] o_heading_cmd,
    output logic                                o_updated,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [davpi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [davpi_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import davpi_pkg::*;

    t_cfg cfg;

    // Stage valid bits and advance conditions.
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic ready1, ready2, ready3, ready4, ready5;
    logic ld1, ld2, ld3, ld4, ld5;

    // Per-stage side information.
    t_tag r_tag1, r_tag2, r_tag3, r_tag4;
    t_tag n_tag1;
    logic signed [VEL_W-1:0] r_meas_x, r_meas_y;

    // Axis datapaths.
    logic signed [ERR_W-1:0]   err_x, err_y;
    logic signed [INTEG_W-1:0] integ_x, integ_y;
    logic signed [NUM_W-1:0]   num_x, num_y;

    // Command state, which is also the output register.
    logic signed [CMD_W-1:0]  r_roll, r_pitch;
    logic signed [HEAD_W-1:0] r_heading;
    logic                     r_updated;

    // A stage can take a new beat when it is empty or its beat moves on.
    assign ready5 = !r_out_valid || !i_stall;
    assign ready4 = !r_v4 || ready5;
    assign ready3 = !r_v3 || ready4;
    assign ready2 = !r_v2 || ready3;
    assign ready1 = !r_v1 || ready2;

    assign ld1 = i_valid && ready1;
    assign ld2 = r_v1 && ready2;
    assign ld3 = r_v2 && ready3;
    assign ld4 = r_v3 && ready4;
    assign ld5 = r_v4 && ready5;

    assign o_stall     = !ready1;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_tag1.heading = i_current_heading;
        if (i_func) begin
            n_tag1.kind = K_ENTER;
        end else if (i_mode_active) begin
            n_tag1.kind = K_UPDATE;
        end else begin
            n_tag1.kind = K_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
            if (ready4) begin
                r_v4 <= r_v3;
            end
            if (ready5) begin
                r_out_valid <= r_v4;
            end
        end
    end

    // Payload registers move only with a valid beat.
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_tag1   <= n_tag1;
            r_meas_x <= i_meas_vel_x;
            r_meas_y <= i_meas_vel_y;
        end
        if (ld2) begin
            r_tag2 <= r_tag1;
        end
        if (ld3) begin
            r_tag3 <= r_tag2;
        end
        if (ld4) begin
            r_tag4 <= r_tag3;
        end
    end

    davpi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    davpi_integ u_integ_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (ld2),
        .i_kind   (r_tag1.kind),
        .i_target (cfg.target_vel_x),
        .i_meas   (r_meas_x),
        .o_err    (err_x),
        .o_integ  (integ_x)
    );

    davpi_integ u_integ_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (ld2),
        .i_kind   (r_tag1.kind),
        .i_target (cfg.target_vel_y),
        .i_meas   (r_meas_y),
        .o_err    (err_y),
        .o_integ  (integ_y)
    );

    davpi_law u_law_x (
        .i_clk    (i_clk),
        .i_ld_mul (ld3),
        .i_ld_sum (ld4),
        .i_p_gain (cfg.pitch_p_gain),
        .i_i_gain (cfg.pitch_i_gain),
        .i_err    (err_x),
        .i_integ  (integ_x),
        .o_num    (num_x)
    );

    davpi_law u_law_y (
        .i_clk    (i_clk),
        .i_ld_mul (ld3),
        .i_ld_sum (ld4),
        .i_p_gain (cfg.roll_p_gain),
        .i_i_gain (cfg.roll_i_gain),
        .i_err    (err_y),
        .i_integ  (integ_y),
        .o_num    (num_y)
    );

    // Command stage: divide, negate pitch, clamp, and hold between updates; enter zeroes and stores heading.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll    <= '0;
            r_pitch   <= '0;
            r_heading <= '0;
            r_updated <= 1'b0;
        end else if (ld5) begin
            case (r_tag4.kind)
                K_ENTER: begin
                    r_roll    <= '0;
                    r_pitch   <= '0;
                    r_heading <= r_tag4.heading;
                    r_updated <= 1'b1;
                end
                K_UPDATE: begin
                    r_roll    <= f_cmd(num_y, 1'b0, cfg.command_limit);
                    r_pitch   <= f_cmd(num_x, 1'b1, cfg.command_limit);
                    r_updated <= 1'b1;
                end
                default: begin
                    r_updated <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_roll_cmd    = r_roll;
    assign o_pitch_cmd   = r_pitch;
    assign o_heading_cmd = r_heading;
    assign o_updated     = r_updated;

    `include "assert_macros.svh"

    `DAVPI_ASSERT_NEXT(a_cmd_hold, i_clk, i_rst_n, i_rst_n && !ld5, $stable(r_roll) && $stable(r_pitch) && $stable(r_heading) && $stable(r_updated), "commands changed with no beat")
    `DAVPI_ASSERT_NEXT(a_enter_zero, i_clk, i_rst_n, ld5 && r_tag4.kind == K_ENTER, r_roll == '0 && r_pitch == '0 && r_updated, "enter beat did not zero commands")
    `DAVPI_ASSERT_NEXT(a_stage4_hold, i_clk, i_rst_n, r_v4 && !ready5, r_v4 && $stable(r_tag4), "stalled stage lost its beat")

endmodule

`default_nettype wire

// ===== src/davpi_cfg.sv =====
// Configuration register file for the dual-axis velocity PI controller.
// Depends on davpi_pkg.
`default_nettype none

module davpi_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [davpi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [davpi_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output davpi_pkg::t_cfg                   o_cfg
);
    import davpi_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.roll_p_gain   <= RST_P_GAIN;
            r_cfg.roll_i_gain   <= RST_I_GAIN;
            r_cfg.pitch_p_gain  <= RST_P_GAIN;
            r_cfg.pitch_i_gain  <= RST_I_GAIN;
            r_cfg.target_vel_x  <= '0;
            r_cfg.target_vel_y  <= '0;
            r_cfg.command_limit <= RST_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROLL_P_GAIN:  r_cfg.roll_p_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_ROLL_I_GAIN:  r_cfg.roll_i_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_PITCH_P_GAIN: r_cfg.pitch_p_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_PITCH_I_GAIN: r_cfg.pitch_i_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_TARGET_VEL_X: r_cfg.target_vel_x  <= $signed(i_cfg_data[VEL_W-1:0]);
                CFG_TARGET_VEL_Y: r_cfg.target_vel_y  <= $signed(i_cfg_data[VEL_W-1:0]);
                CFG_CMD_LIMIT:    r_cfg.command_limit <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/davpi_integ.sv =====
// Velocity error and saturating integrator for one axis.
// Depends on davpi_pkg and assert_macros.svh.
`default_nettype none

module davpi_integ (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  davpi_pkg::t_kind                    i_kind,
    input  logic signed [davpi_pkg::VEL_W-1:0]  i_target,
    input  logic signed [davpi_pkg::VEL_W-1:0]  i_meas,
    output logic signed [davpi_pkg::ERR_W-1:0]  o_err,
    output logic signed [davpi_pkg::INTEG_W-1:0] o_integ
);
    import davpi_pkg::*;

    localparam int SUM_W = INTEG_W + 1;
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    logic signed [ERR_W-1:0]   r_err;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [INTEG_W-1:0] n_integ;
    logic signed [SUM_W-1:0]   sum;

    assign n_err = ERR_W'(i_target) - ERR_W'(i_meas);
    assign sum   = SUM_W'(r_integ) + SUM_W'(n_err);

    always_comb begin
        case (i_kind)
            K_ENTER:  n_integ = '0;
            K_UPDATE: begin
                if (sum[SUM_W-1] != sum[SUM_W-2]) begin
                    n_integ = sum[SUM_W-1] ? INTEG_MIN : INTEG_MAX;
                end else begin
                    n_integ = sum[INTEG_W-1:0];
                end
            end
            default:  n_integ = r_integ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_adv) begin
            r_integ <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_err <= n_err;
        end
    end

    assign o_err   = r_err;
    assign o_integ = r_integ;

    `include "assert_macros.svh"

    `DAVPI_ASSERT_NEXT(a_integ_holds, i_clk, i_rst_n, i_rst_n && !i_adv, $stable(r_integ), "integrator moved without an item")
    `DAVPI_ASSERT_NEXT(a_integ_enter, i_clk, i_rst_n, i_adv && i_kind == K_ENTER, r_integ == '0, "enter did not clear integrator")

endmodule

`default_nettype wire

// ===== src/davpi_law.sv =====
// PI law for one axis: gain products, then the combined numerator.
// Depends on davpi_pkg.
`default_nettype none

module davpi_law (
    input  logic                                 i_clk,
    input  logic                                 i_ld_mul,
    input  logic                                 i_ld_sum,
    input  logic [davpi_pkg::GAIN_W-1:0]         i_p_gain,
    input  logic [davpi_pkg::GAIN_W-1:0]         i_i_gain,
    input  logic signed [davpi_pkg::ERR_W-1:0]   i_err,
    input  logic signed [davpi_pkg::INTEG_W-1:0] i_integ,
    output logic signed [davpi_pkg::NUM_W-1:0]   o_num
);
    import davpi_pkg::*;

    logic signed [PROD_P_W-1:0] r_prod_p;
    logic signed [PROD_P_W-1:0] n_prod_p;
    logic signed [PROD_I_W-1:0] r_prod_i;
    logic signed [PROD_I_W-1:0] n_prod_i;
    logic signed [NUM_W-1:0]    r_num;
    logic signed [NUM_W-1:0]    n_num;

    assign n_prod_p = $signed({1'b0, i_p_gain}) * i_err;
    assign n_prod_i = $signed({1'b0, i_i_gain}) * i_integ;
    // The proportional term is lifted by the integrator weight so one divide suffices.
    assign n_num    = (NUM_W'(r_prod_p) <<< INTEG_SHIFT) + NUM_W'(r_prod_i);

    always_ff @(posedge i_clk) begin
        if (i_ld_mul) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
        end
        if (i_ld_sum) begin
            r_num <= n_num;
        end
    end

    assign o_num = r_num;

endmodule

`default_nettype wire
